/* src/rkrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkrb_pkg
// Shared types and constants of the remappable key report builder.
// ----------------------------------------------------------------------------
package rkrb_pkg;

  localparam int NUM_KEYS      = 7;
  localparam int TIMEOUT_TICKS = 100;

  localparam int CodeW     = 8;
  localparam int TickW     = 8;
  localparam int MaskW     = 7;
  localparam int KeyW      = 7;
  localparam int CountW    = 3;
  localparam int SlotCnt   = 6;
  localparam int TableMax  = 7;
  localparam int RxCntW    = $clog2(NUM_KEYS + 2);
  localparam int RxIdxW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam logic [CodeW-1:0] DefaultCodes [TableMax] = '{
    8'h4F, 8'h50, 8'h51, 8'h52, 8'h04, 8'h05, 8'h06
  };

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_REPORT = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic             rx_valid;
    logic [CodeW-1:0] rx_byte;
    logic [KeyW-1:0]  key_pressed;
  } rkrb_in_t;

  typedef struct packed {
    logic [CodeW-1:0]  slot_0;
    logic [CodeW-1:0]  slot_1;
    logic [CodeW-1:0]  slot_2;
    logic [CodeW-1:0]  slot_3;
    logic [CodeW-1:0]  slot_4;
    logic [CodeW-1:0]  slot_5;
    logic [CountW-1:0] pressed_count;
    logic [MaskW-1:0]  changed_mask;
  } rkrb_out_t;

  typedef struct packed {
    logic             fire;
    logic             rx_valid;
    logic [CodeW-1:0] rx_byte;
  } tick_req_t;

  typedef logic [NUM_KEYS-1:0][CodeW-1:0] code_table_t;
  typedef logic [SlotCnt-1:0][CodeW-1:0]  slots_t;

endpackage

/* src/rkrb_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkrb_state
// Tick counter, receive buffer and key code table with timeout commit.
// ----------------------------------------------------------------------------
module rkrb_state
  import rkrb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tick_req_t        req_i,
  output code_table_t      table_o,
  output logic [MaskW-1:0] changed_mask_o
);

  logic [TickW-1:0]  tick_q, tick_d, tick_inc;
  logic [RxCntW-1:0] rxcnt_q, rxcnt_d, rxcnt_upd;
  code_table_t       buf_q, buf_d;
  code_table_t       table_q, table_d;
  logic              buf_wr;
  logic              timeout_hit;
  logic [NUM_KEYS-1:0] diff;

  assign tick_inc    = tick_q + TickW'(1);
  assign timeout_hit = (tick_inc >= TickW'(TIMEOUT_TICKS));
  assign buf_wr      = req_i.fire && req_i.rx_valid && (rxcnt_q < RxCntW'(NUM_KEYS));

  always_comb begin
    buf_d = buf_q;
    if (buf_wr) begin
      buf_d[rxcnt_q[RxIdxW-1:0]] = req_i.rx_byte;
    end
  end

  always_comb begin
    rxcnt_upd = rxcnt_q;
    if (req_i.rx_valid) begin
      if (rxcnt_q < RxCntW'(NUM_KEYS)) begin
        rxcnt_upd = rxcnt_q + RxCntW'(1);
      end else begin
        rxcnt_upd = RxCntW'(NUM_KEYS + 1);
      end
    end
  end

  always_comb begin
    tick_d  = tick_q;
    rxcnt_d = rxcnt_q;
    table_d = table_q;
    diff    = '0;
    if (req_i.fire) begin
      tick_d  = tick_inc;
      rxcnt_d = rxcnt_upd;
      if (timeout_hit) begin
        tick_d  = '0;
        rxcnt_d = '0;
        if (rxcnt_upd == RxCntW'(NUM_KEYS)) begin
          for (int i = 0; i < NUM_KEYS; i++) begin
            diff[i] = (table_q[i] != buf_d[i]);
          end
          table_d = buf_d;
        end
      end
    end
  end

  assign table_o        = table_q;
  assign changed_mask_o = MaskW'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      rxcnt_q <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        table_q[i] <= DefaultCodes[i];
      end
    end else begin
      tick_q  <= tick_d;
      rxcnt_q <= rxcnt_d;
      table_q <= table_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

`ifndef SYNTHESIS
  a_rxcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rxcnt_q <= RxCntW'(NUM_KEYS + 1))
    else $error("receive count out of range");

  a_mask_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (changed_mask_o != '0) |-> (req_i.fire && timeout_hit))
    else $error("changed mask outside a timeout tick");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.fire && timeout_hit) |=> (tick_q == '0 && rxcnt_q == '0))
    else $error("timeout did not clear counters");
`endif

endmodule

/* src/rkrb_pack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkrb_pack
// Packs the codes of pressed keys, lowest key first, into six report slots.
// ----------------------------------------------------------------------------
module rkrb_pack
  import rkrb_pkg::*;
(
  input  code_table_t       table_i,
  input  logic [KeyW-1:0]   key_pressed_i,
  output slots_t            slots_o,
  output logic [CountW-1:0] count_o
);

  always_comb begin
    logic [CountW-1:0] used;
    used    = '0;
    slots_o = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (key_pressed_i[i] && (used < CountW'(SlotCnt))) begin
        slots_o[used] = table_i[i];
        used          = used + CountW'(1);
      end
    end
    count_o = used;
  end

endmodule

/* src/remappable_key_report_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remappable_key_report_builder
// Remappable key table with serial reload and six-slot key report packing.
// ----------------------------------------------------------------------------
// channel  | handshake               | beat
// in       | in_valid_i / in_stall_o | rkrb_in_t  in_data_i
// out      | out_valid_o/ out_stall_i| rkrb_out_t out_data_o
//
// one beat per cycle sustained while out is not stalled; a taken beat moves
// through the input register, then the result register
// state is updated as an item moves from the input to the result register
// reset clears counters and loads the default code table
// an out stall holds the result and stalls in only once the input register
// is also full
// ----------------------------------------------------------------------------
module remappable_key_report_builder
  import rkrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rkrb_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rkrb_out_t out_data_o
);

  logic        s1_valid_q, s1_valid_d;
  rkrb_in_t    s1_data_q;
  logic        out_valid_q, out_valid_d;
  rkrb_out_t   out_data_q, out_data_d;
  logic        s2_ready, s1_adv, in_acc;
  tick_req_t   req;
  code_table_t table_w;
  logic [MaskW-1:0]  mask_w;
  slots_t            slots_w;
  logic [CountW-1:0] count_w;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign req.fire     = s1_adv && (s1_data_q.action == ACT_TICK);
  assign req.rx_valid = s1_data_q.rx_valid;
  assign req.rx_byte  = s1_data_q.rx_byte;

  rkrb_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .table_o        (table_w),
    .changed_mask_o (mask_w)
  );

  rkrb_pack u_pack (
    .table_i       (table_w),
    .key_pressed_i (s1_data_q.key_pressed),
    .slots_o       (slots_w),
    .count_o       (count_w)
  );

  always_comb begin
    out_data_d = '0;
    if (s1_data_q.action == ACT_REPORT) begin
      out_data_d.slot_0        = slots_w[0];
      out_data_d.slot_1        = slots_w[1];
      out_data_d.slot_2        = slots_w[2];
      out_data_d.slot_3        = slots_w[3];
      out_data_d.slot_4        = slots_w[4];
      out_data_d.slot_5        = slots_w[5];
      out_data_d.pressed_count = count_w;
    end else begin
      out_data_d.changed_mask  = mask_w;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s2_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced beat lost");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
`endif

endmodule

/* sim/remappable_key_report_builder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remappable_key_report_builder_test
// Self-checking bench for the remappable key report builder. A short table of
// report and tick beats runs first. Then random windows of frame ticks carry
// seven, fewer or too many remap bytes, with key reports mixed in. Every
// result is compared against the table's expected value or a local model of
// the code table, the receive buffer and the report packing. The sender uses
// bursts and gaps, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module remappable_key_report_builder_test;
  import rkrb_pkg::*;

  localparam int NumDirected = 16;
  localparam int NumRandom   = 850;

  typedef struct packed {
    rkrb_in_t  beat;
    logic      fixed;
    rkrb_out_t want;
  } directed_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_COMB,
    STALL_HEAVY
  } stall_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  rkrb_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  rkrb_out_t out_data_o;

  // model state
  logic [TickW-1:0] tick_ctr;
  int               byte_cnt;
  logic [CodeW-1:0] rx_buf    [NUM_KEYS];
  logic [CodeW-1:0] key_codes [NUM_KEYS];

  rkrb_out_t   expected_reports [$];
  rkrb_out_t   oldest_report;
  int          mismatch_cnt = 0;
  int          commit_cnt = 0;
  int          blocked_cnt = 0;
  int          report_cnt = 0;
  int          full_report_cnt = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_hold = 0;

  // keys 0..6 default to 4F 50 51 52 04 05 06
  directed_row_t directed_rows [NumDirected] = '{
    '{'{ACT_REPORT, 1'b0, 8'h00, 7'h00}, 1'b1, '0},
    '{'{ACT_REPORT, 1'b0, 8'h00, 7'h7F}, 1'b1,
      '{8'h4F, 8'h50, 8'h51, 8'h52, 8'h04, 8'h05, 3'd6, 7'h00}},
    '{'{ACT_REPORT, 1'b0, 8'hFF, 7'h40}, 1'b1,
      '{8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 7'h00}},
    '{'{ACT_REPORT, 1'b1, 8'hFF, 7'h01}, 1'b1,
      '{8'h4F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 7'h00}},
    '{'{ACT_REPORT, 1'b0, 8'h00, 7'h3F}, 1'b1,
      '{8'h4F, 8'h50, 8'h51, 8'h52, 8'h04, 8'h05, 3'd6, 7'h00}},
    '{'{ACT_TICK,   1'b0, 8'hFF, 7'h7F}, 1'b1, '0},
    '{'{ACT_TICK,   1'b1, 8'h4F, 7'h00}, 1'b0, '0},
    '{'{ACT_TICK,   1'b1, 8'hFF, 7'h00}, 1'b0, '0},
    '{'{ACT_TICK,   1'b0, 8'h00, 7'h2A}, 1'b0, '0},
    '{'{ACT_TICK,   1'b1, 8'h00, 7'h00}, 1'b0, '0},
    '{'{ACT_TICK,   1'b1, 8'hAA, 7'h55}, 1'b0, '0},
    '{'{ACT_TICK,   1'b1, 8'h55, 7'h00}, 1'b0, '0},
    '{'{ACT_TICK,   1'b1, 8'h05, 7'h00}, 1'b0, '0},
    '{'{ACT_TICK,   1'b1, 8'h80, 7'h00}, 1'b0, '0},
    '{'{ACT_REPORT, 1'b0, 8'h00, 7'h55}, 1'b0, '0},
    '{'{ACT_REPORT, 1'b1, 8'h00, 7'h2A}, 1'b0, '0}
  };

  remappable_key_report_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic remap_and_pack(input rkrb_in_t beat, output rkrb_out_t res);
    slots_t slots;
    int     used;
    res   = '0;
    slots = '0;
    used  = 0;
    if (action_e'(beat.action) == ACT_TICK) begin
      tick_ctr = tick_ctr + 1'b1;
      if (beat.rx_valid) begin
        if (byte_cnt < NUM_KEYS) begin
          rx_buf[byte_cnt] = beat.rx_byte;
          byte_cnt++;
        end else begin
          byte_cnt = NUM_KEYS + 1;
        end
      end
      if (tick_ctr >= TIMEOUT_TICKS) begin
        tick_ctr = '0;
        if (byte_cnt == NUM_KEYS) begin
          commit_cnt++;
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (key_codes[i] != rx_buf[i]) begin
              key_codes[i]        = rx_buf[i];
              res.changed_mask[i] = 1'b1;
            end
          end
        end else if (byte_cnt > NUM_KEYS) begin
          blocked_cnt++;
        end
        byte_cnt = 0;
      end
    end else begin
      report_cnt++;
      if (&beat.key_pressed) full_report_cnt++;
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (beat.key_pressed[i] && used < SlotCnt) begin
          slots[used] = key_codes[i];
          used++;
        end
      end
      res.slot_0        = slots[0];
      res.slot_1        = slots[1];
      res.slot_2        = slots[2];
      res.slot_3        = slots[3];
      res.slot_4        = slots[4];
      res.slot_5        = slots[5];
      res.pressed_count = CountW'(used);
    end
  endtask

  // holds the beat until taken, then records what it should produce
  task automatic send_beat(input rkrb_in_t beat, input logic fixed, input rkrb_out_t want);
    rkrb_out_t predicted;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    remap_and_pack(beat, predicted);
    expected_reports.push_back(fixed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // receiver stall patterns
  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(20, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_COMB:  out_stall_i <= (stall_hold % 3 == 0);
      default:     out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data_o);
        mismatch_cnt++;
      end else begin
        oldest_report = expected_reports.pop_front();
        check_field("slot_0", oldest_report.slot_0, out_data_o.slot_0);
        check_field("slot_1", oldest_report.slot_1, out_data_o.slot_1);
        check_field("slot_2", oldest_report.slot_2, out_data_o.slot_2);
        check_field("slot_3", oldest_report.slot_3, out_data_o.slot_3);
        check_field("slot_4", oldest_report.slot_4, out_data_o.slot_4);
        check_field("slot_5", oldest_report.slot_5, out_data_o.slot_5);
        check_field("pressed_count", 8'(oldest_report.pressed_count),
                    8'(out_data_o.pressed_count));
        check_field("changed_mask", 8'(oldest_report.changed_mask),
                    8'(out_data_o.changed_mask));
      end
    end
  end

  initial begin
    rkrb_in_t beat;
    int       gen_target;
    int       gen_sent;
    int       burst_left;
    int       ticks_left;
    int       bytes_left;
    int       pick;

    tick_ctr = '0;
    byte_cnt = 0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      rx_buf[i]    = '0;
      key_codes[i] = DefaultCodes[i];
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumDirected; r++) begin
      send_beat(directed_rows[r].beat, directed_rows[r].fixed, directed_rows[r].want);
    end
    drain_results();

    // finish the window that the table started, then plan whole windows
    gen_sent   = byte_cnt;
    gen_target = (byte_cnt <= NUM_KEYS) ? NUM_KEYS : byte_cnt;
    burst_left = 0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 200 == 199) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) begin
          repeat ($urandom_range(1, 8)) begin
            @(negedge clk_i);
            in_valid_i <= 1'b0;
          end
        end
      end
      burst_left--;

      beat.rx_byte     = 8'($urandom);
      beat.key_pressed = ($urandom_range(0, 5) == 0) ? 7'h7F : 7'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        beat.action   = ACT_REPORT;
        beat.rx_valid = 1'($urandom);
      end else begin
        beat.action   = ACT_TICK;
        ticks_left    = TIMEOUT_TICKS - int'(tick_ctr);
        bytes_left    = gen_target - gen_sent;
        beat.rx_valid = (bytes_left > 0) &&
                        (bytes_left >= ticks_left ||
                         $urandom_range(0, ticks_left - 1) < bytes_left);
        if (beat.rx_valid) begin
          gen_sent++;
          if (byte_cnt < NUM_KEYS && $urandom_range(0, 1) == 0) begin
            beat.rx_byte = key_codes[byte_cnt];
          end
        end
      end
      send_beat(beat, 1'b0, '0);

      if (action_e'(beat.action) == ACT_TICK && tick_ctr == '0) begin
        gen_sent = 0;
        pick     = $urandom_range(0, 19);
        if (pick <= 12) begin
          gen_target = NUM_KEYS;
        end else if (pick <= 15) begin
          gen_target = $urandom_range(NUM_KEYS + 1, NUM_KEYS + 5);
        end else begin
          gen_target = $urandom_range(0, NUM_KEYS - 1);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d remap commits, %0d overrun rounds blocked, %0d key reports",
             commit_cnt, blocked_cnt, report_cnt);
    $display("%0d reports had all seven keys pressed, %0d mismatches",
             full_report_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_reports.size() == 0) begin
      $display("[remappable_key_report_builder] OK");
    end else begin
      $display("[remappable_key_report_builder] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_reports.size());
    $display("[remappable_key_report_builder] ERROR");
    $finish;
  end

endmodule
